// ===== sv/conv2d_relu_line_buffer_macros.svh =====
// assertion macros for the conv2d relu line buffer block
// no dependencies; included by files that assert
`ifndef CONV2D_RELU_LINE_BUFFER_MACROS_SVH
`define CONV2D_RELU_LINE_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define CRLB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crlb assertion failed");
`define CRLB_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("crlb assertion failed");
`else
`define CRLB_ASSERT(lbl, clk, rst, prop)
`define CRLB_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== sv/crlb_pkg.sv =====
// shared types and constants for the conv2d relu line buffer block
// no dependencies
package crlb_pkg;
  localparam int IMAGE_WIDTH  = 32;
  localparam int KERNEL_SIZE  = 3;
  localparam int NUM_CHANNELS = 4;
  localparam int NUM_FILTERS  = 8;
  localparam int FX_BITS      = 24;
  localparam int FX_FRAC      = 4 * 5;

  localparam int LINE_DEPTH   = (KERNEL_SIZE - 1) * IMAGE_WIDTH * NUM_CHANNELS
                                + KERNEL_SIZE * NUM_CHANNELS;
  localparam int TAPS         = KERNEL_SIZE * KERNEL_SIZE * NUM_CHANNELS;
  localparam int WEIGHT_DEPTH = TAPS * NUM_FILTERS;
  localparam int ROW_STEP     = (IMAGE_WIDTH - KERNEL_SIZE) * NUM_CHANNELS + 1;

  localparam int LA_W  = $clog2(LINE_DEPTH);
  localparam int WA_W  = $clog2(WEIGHT_DEPTH);
  localparam int TAP_W = $clog2(TAPS);
  localparam int F_W   = $clog2(NUM_FILTERS);
  localparam int POS_W = $clog2(IMAGE_WIDTH);
  localparam int CH_W  = $clog2(NUM_CHANNELS);

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_BIAS   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [FX_BITS-1:0] value;
    logic [1:0]                kernel_row;
    logic [1:0]                kernel_col;
    logic [1:0]                in_channel;
    logic [2:0]                filter_sel;
  } in_t;

  typedef struct packed {
    logic [FX_BITS-2:0] activation;
    logic [2:0]         filter_index;
    logic               last_of_run;
  } out_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;
endpackage

// ===== sv/crlb_mac.sv =====
// multiply-accumulate unit: registered product, floored to fraction bits, wrapping sum
// depends on crlb_pkg
module crlb_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  crlb_pkg::mac_ctrl_t                ctrl,
  input  logic signed [crlb_pkg::FX_BITS-1:0] sample,
  input  logic signed [crlb_pkg::FX_BITS-1:0] weight,
  output logic                               sum_vld,
  output logic [crlb_pkg::FX_BITS-1:0]       sum
);
  import crlb_pkg::*;

  mac_ctrl_t                   ctrl_q;
  logic signed [2*FX_BITS-1:0] prod;
  logic [FX_BITS-1:0]          prod_fx;
  logic [FX_BITS-1:0]          acc;

  assign prod_fx = prod[FX_FRAC+FX_BITS-1:FX_FRAC];
  assign sum     = acc;

  always_ff @(posedge clk) begin
    prod <= sample * weight;
    if (ctrl_q.vld) begin
      acc <= ctrl_q.first ? prod_fx : acc + prod_fx;
    end
    if (rst) begin
      ctrl_q  <= '0;
      sum_vld <= 1'b0;
    end else begin
      ctrl_q  <= ctrl;
      sum_vld <= ctrl_q.vld & ctrl_q.last;
    end
  end
endmodule

// ===== sv/conv2d_relu_line_buffer.sv =====
// A sample that completes no window is taken while the block is idle, as are
// weight and bias loads. The last channel of a pixel that closes a KxK window
// starts a pass over the weight and line memories with one shared multiplier:
// each filter reads its 36 taps, drains the multiplier pipeline and then hands
// over its word, and no input is taken until all 8 filters are done. The line
// memory is a 268-entry circular buffer written once per sample; it is always
// full before the first window.
// depends on crlb_pkg, crlb_mac and conv2d_relu_line_buffer_macros.svh
`include "conv2d_relu_line_buffer_macros.svh"
module conv2d_relu_line_buffer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  crlb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output crlb_pkg::out_t out_data
);
  import crlb_pkg::*;

  logic [FX_BITS-1:0] line_mem [LINE_DEPTH];
  logic [FX_BITS-1:0] weight_mem [WEIGHT_DEPTH];
  logic [FX_BITS-1:0] bias_mem [NUM_FILTERS];

  state_t             state;
  logic [LA_W-1:0]    wptr, wptr_next;
  logic [LA_W-1:0]    base;
  logic [LA_W-1:0]    laddr, laddr_next;
  logic [LA_W:0]      laddr_sum;
  logic [TAP_W-1:0]   tap;
  logic [CH_W-1:0]    ch_cnt;
  logic [1:0]         kc_cnt;
  logic [F_W-1:0]     filt;
  logic [CH_W-1:0]    chan_pos;
  logic [POS_W-1:0]   pix_col, pix_row;
  logic [FX_BITS-1:0] line_q, weight_q, bias_q;
  mac_ctrl_t          issue, issue_q;
  logic               sum_vld;
  logic [FX_BITS-1:0] sum, biased;
  out_t               res;
  logic               slot_free;
  logic               take, is_sample, last_chan, win_done;
  logic [WA_W-1:0]    wr_idx;
  logic               wr_ok;
  logic               last_emit;

  assign in_ready  = (state == S_IDLE);
  assign take      = in_valid & in_ready;
  assign is_sample = take && (in_data.cmd == CMD_SAMPLE);
  assign last_chan = (chan_pos == CH_W'(NUM_CHANNELS - 1));
  assign win_done  = (pix_row >= POS_W'(KERNEL_SIZE - 1))
                     && (pix_col >= POS_W'(KERNEL_SIZE - 1));
  assign slot_free = !out_valid || out_ready;
  assign last_emit = (state == S_EMIT) && slot_free && (filt == F_W'(NUM_FILTERS - 1));
  assign wptr_next = (wptr == LA_W'(LINE_DEPTH - 1)) ? '0 : wptr + 1'b1;

  assign wr_idx = WA_W'(((32'(in_data.kernel_row) * KERNEL_SIZE + 32'(in_data.kernel_col))
                  * NUM_CHANNELS + 32'(in_data.in_channel)) * NUM_FILTERS
                  + 32'(in_data.filter_sel));
  assign wr_ok  = (32'(in_data.kernel_row) < KERNEL_SIZE)
                  && (32'(in_data.kernel_col) < KERNEL_SIZE)
                  && (32'(in_data.in_channel) < NUM_CHANNELS)
                  && (32'(in_data.filter_sel) < NUM_FILTERS);

  // next window address: channels and kernel columns are contiguous, rows jump
  always_comb begin
    if ((ch_cnt == CH_W'(NUM_CHANNELS - 1)) && (kc_cnt == 2'(KERNEL_SIZE - 1))) begin
      laddr_sum = {1'b0, laddr} + (LA_W + 1)'(ROW_STEP);
    end else begin
      laddr_sum = {1'b0, laddr} + 1'b1;
    end
    if (laddr_sum >= (LA_W + 1)'(LINE_DEPTH)) begin
      laddr_next = LA_W'(laddr_sum - (LA_W + 1)'(LINE_DEPTH));
    end else begin
      laddr_next = laddr_sum[LA_W-1:0];
    end
  end

  assign issue.vld   = (state == S_RUN);
  assign issue.first = (tap == '0);
  assign issue.last  = (tap == TAP_W'(TAPS - 1));

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (is_sample) begin
      line_mem[wptr] <= in_data.value;
    end
    if (take && (in_data.cmd == CMD_WEIGHT) && wr_ok) begin
      weight_mem[wr_idx] <= in_data.value;
    end
    if (take && (in_data.cmd == CMD_BIAS) && (32'(in_data.filter_sel) < NUM_FILTERS)) begin
      bias_mem[F_W'(in_data.filter_sel)] <= in_data.value;
    end
    line_q   <= line_mem[laddr];
    weight_q <= weight_mem[WA_W'({tap, filt})];
    bias_q   <= bias_mem[filt];
  end

  crlb_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (issue_q),
    .sample  (line_q),
    .weight  (weight_q),
    .sum_vld (sum_vld),
    .sum     (sum)
  );

  assign biased = sum + bias_q;

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      res.activation   <= biased[FX_BITS-1] ? '0 : biased[FX_BITS-2:0];
      res.filter_index <= 3'(filt);
      res.last_of_run  <= (filt == F_W'(NUM_FILTERS - 1));
    end
    if (state == S_EMIT && slot_free) begin
      out_data <= res;
    end
    if (rst) begin
      state    <= S_IDLE;
      wptr     <= '0;
      base     <= '0;
      laddr    <= '0;
      tap      <= '0;
      ch_cnt   <= '0;
      kc_cnt   <= '0;
      filt     <= '0;
      chan_pos <= '0;
      pix_col  <= '0;
      pix_row  <= '0;
      issue_q  <= '0;
      out_valid <= 1'b0;
    end else begin
      issue_q <= issue;
      // word stays until taken; a new one loads when the slot is free
      if ((state == S_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (is_sample) begin
            wptr <= wptr_next;
            if (last_chan) begin
              chan_pos <= '0;
              if (pix_col == POS_W'(IMAGE_WIDTH - 1)) begin
                pix_col <= '0;
                pix_row <= (pix_row == POS_W'(IMAGE_WIDTH - 1)) ? '0 : pix_row + 1'b1;
              end else begin
                pix_col <= pix_col + 1'b1;
              end
              if (win_done) begin
                // oldest entry is the top-left sample of the window
                base   <= wptr_next;
                laddr  <= wptr_next;
                tap    <= '0;
                ch_cnt <= '0;
                kc_cnt <= '0;
                filt   <= '0;
                state  <= S_RUN;
              end
            end else begin
              chan_pos <= chan_pos + 1'b1;
            end
          end
        end
        S_RUN: begin
          laddr <= laddr_next;
          if (ch_cnt == CH_W'(NUM_CHANNELS - 1)) begin
            ch_cnt <= '0;
            kc_cnt <= (kc_cnt == 2'(KERNEL_SIZE - 1)) ? '0 : kc_cnt + 1'b1;
          end else begin
            ch_cnt <= ch_cnt + 1'b1;
          end
          if (tap == TAP_W'(TAPS - 1)) begin
            state <= S_DRAIN;
          end else begin
            tap <= tap + 1'b1;
          end
        end
        S_DRAIN: begin
          if (sum_vld) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (filt == F_W'(NUM_FILTERS - 1)) begin
              state <= S_IDLE;
            end else begin
              filt   <= filt + 1'b1;
              laddr  <= base;
              tap    <= '0;
              ch_cnt <= '0;
              kc_cnt <= '0;
              state  <= S_RUN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CRLB_ASSERT(a_sum_in_drain, clk, rst, sum_vld |-> (state == S_DRAIN))
  `CRLB_ASSERT(a_tap_range, clk, rst, (state == S_RUN) |-> (tap <= TAP_W'(TAPS - 1)))
  `CRLB_ASSERT_NEXT(a_last_to_idle, clk, rst, last_emit, (state == S_IDLE) && out_valid && out_data.last_of_run)
endmodule
